// File: sv/tsp_pkg.sv
`default_nettype none

package tsp_pkg;

    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    // Depth of the token queue between the front and back ends
    localparam int unsigned TOK_QUEUE_DEPTH = 4;

    // Size qualifier codes
    localparam logic [2:0] SZ_NORMAL = 3'd0;
    localparam logic [2:0] SZ_LONG   = 3'd1;
    localparam logic [2:0] SZ_LLONG  = 3'd2;
    localparam logic [2:0] SZ_SHORT  = 3'd7;

    // Sign qualifier codes
    localparam logic [1:0] SG_NONE     = 2'd0;
    localparam logic [1:0] SG_SIGNED   = 2'd1;
    localparam logic [1:0] SG_UNSIGNED = 2'd2;

    // Token positions
    localparam logic [2:0] POS_START = 3'd0;
    localparam logic [2:0] POS_SIGN  = 3'd1;
    localparam logic [2:0] POS_SIZE  = 3'd2;
    localparam logic [2:0] POS_LLONG = 3'd3;
    localparam logic [2:0] POS_BASE  = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNEXPECT = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] ST_BAD_SIGN = 2'd3;

    // Type code fixed parts
    localparam logic [10:0] CODE_FLOAT  = 11'h300;
    localparam logic [10:0] CODE_DOUBLE = 11'h400;
    localparam logic [2:0]  INT_BIAS    = 3'd2;

    typedef enum logic [1:0] {
        BK_CHAR   = 2'd0,
        BK_INT    = 2'd1,
        BK_FLOAT  = 2'd2,
        BK_DOUBLE = 2'd3
    } t_base;

    // One finished token handed from front to back
    typedef struct packed {
        logic [31:0] hash;
        logic        last;
    } t_tok;

    // Queue handshake toward the front end
    typedef struct packed {
        logic push;
        logic full;
    } t_qpush;

    // Hash of a keyword of up to eight characters, last character in [7:0]
    function automatic logic [31:0] fnv_const(input logic [63:0] s, input int unsigned n);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int unsigned i = 0; i < 8; i++) begin
            if (i < n) begin
                h = (h ^ {24'b0, s[8 * (n - 1 - i) +: 8]}) * FNV_PRIME;
            end
        end
        return h;
    endfunction

    localparam logic [31:0] KW_SIGNED   = fnv_const("signed", 6);
    localparam logic [31:0] KW_UNSIGNED = fnv_const("unsigned", 8);
    localparam logic [31:0] KW_SHORT    = fnv_const("short", 5);
    localparam logic [31:0] KW_LONG     = fnv_const("long", 4);
    localparam logic [31:0] KW_CHAR     = fnv_const("char", 4);
    localparam logic [31:0] KW_INT      = fnv_const("int", 3);
    localparam logic [31:0] KW_FLOAT    = fnv_const("float", 5);
    localparam logic [31:0] KW_DOUBLE   = fnv_const("double", 6);

endpackage

`default_nettype wire

// File: sv/tsp_in_if.sv
`default_nettype none

interface tsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       token_end;
    logic       name_end;

    modport source (output valid, output char_byte, output token_end, output name_end,
                    input ready);
    modport sink (input valid, input char_byte, input token_end, input name_end,
                  output ready);
endinterface

`default_nettype wire

// File: sv/tsp_out_if.sv
`default_nettype none

interface tsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [10:0] type_code;

    modport source (output valid, output status, output type_code, input ready);
    modport sink (input valid, input status, input type_code, output ready);
endinterface

`default_nettype wire

// File: sv/tsp_front.sv
`default_nettype none

module tsp_front
    import tsp_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    tsp_in_if.sink  i_in,
    input  wire     i_q_full,
    output logic    o_push,
    output t_tok    o_tok
);

    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic        accept;
    logic        tok_done;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign tok_done   = i_in.token_end || i_in.name_end;

    // Hash step: xor in the character, multiply by the prime
    assign n_hash = (r_hash ^ {24'b0, i_in.char_byte}) * FNV_PRIME;

    assign o_push     = accept && tok_done;
    assign o_tok.hash = n_hash;
    assign o_tok.last = i_in.name_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
        end else if (accept) begin
            r_hash <= tok_done ? FNV_BASIS : n_hash;
        end
    end

`ifndef SYNTHESIS
    a_hash_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && tok_done) |=> r_hash == FNV_BASIS)
        else $error("hash not restarted after token end");
`endif

endmodule

`default_nettype wire

// File: sv/tsp_queue.sv
`default_nettype none

module tsp_queue
    import tsp_pkg::*;
#(
    parameter int unsigned DEPTH = TOK_QUEUE_DEPTH
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_qpush  i_ctl,
    input  t_tok    i_tok,
    output logic    o_full,
    output logic    o_valid,
    output t_tok    o_tok,
    input  wire     i_pop
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_tok            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];
    assign do_push = i_ctl.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.push && i_ctl.full))
        else $error("token pushed into full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// File: sv/tsp_back.sv
`default_nettype none

module tsp_back
    import tsp_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_q_valid,
    input  t_tok     i_tok,
    output logic     o_pop,
    tsp_out_if.source o_out
);

    logic [2:0]  r_pos,  n_pos;
    logic [1:0]  r_sign, n_sign;
    logic [2:0]  r_size, n_size;
    t_base       r_base, n_base;
    logic [1:0]  r_err,  n_err;

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [10:0] r_code;

    logic        out_free;
    logic        emit;
    logic        k_sgn, k_uns, k_sh, k_lg, k_ch, k_int, k_fl, k_db;
    logic [1:0]  res_status;
    logic [1:0]  res_sign;
    logic [10:0] res_code;

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = i_q_valid && (!i_tok.last || out_free);
    assign emit     = o_pop && i_tok.last;

    assign k_sgn = (i_tok.hash == KW_SIGNED);
    assign k_uns = (i_tok.hash == KW_UNSIGNED);
    assign k_sh  = (i_tok.hash == KW_SHORT);
    assign k_lg  = (i_tok.hash == KW_LONG);
    assign k_ch  = (i_tok.hash == KW_CHAR);
    assign k_int = (i_tok.hash == KW_INT);
    assign k_fl  = (i_tok.hash == KW_FLOAT);
    assign k_db  = (i_tok.hash == KW_DOUBLE);

    // Position machine over one finished token; hold everything after an error
    always_comb begin
        n_pos  = r_pos;
        n_sign = r_sign;
        n_size = r_size;
        n_base = r_base;
        n_err  = r_err;
        if (r_err == ST_OK) begin
            priority if (r_pos == POS_START && (k_sgn || k_uns)) begin
                n_sign = k_uns ? SG_UNSIGNED : SG_SIGNED;
                n_pos  = POS_SIGN;
            end else if (r_pos <= POS_SIGN && (k_sh || k_lg)) begin
                n_size = k_lg ? SZ_LONG : SZ_SHORT;
                n_pos  = POS_SIZE;
            end else if (r_pos <= POS_SIZE && (k_sh || k_lg)) begin
                if (!k_lg || r_size != SZ_LONG) begin
                    n_err = ST_BAD_SIZE;
                end else begin
                    n_size = SZ_LLONG;
                    n_pos  = POS_LLONG;
                end
            end else if (r_pos <= POS_LLONG && (k_ch || k_int || k_fl || k_db)) begin
                priority if (k_ch) begin
                    n_base = BK_CHAR;
                end else if (k_fl) begin
                    n_base = BK_FLOAT;
                end else if (k_db) begin
                    n_base = BK_DOUBLE;
                end else begin
                    n_base = r_base;
                end
                n_pos = POS_BASE;
            end else begin
                n_err = ST_UNEXPECT;
            end
        end
    end

    // Validate the combination and pack the type code
    always_comb begin
        res_status = n_err;
        res_sign   = n_sign;
        res_code   = '0;
        if (res_status == ST_OK) begin
            if (n_sign != SG_NONE) begin
                if (n_base == BK_FLOAT || n_base == BK_DOUBLE) begin
                    res_status = ST_BAD_SIGN;
                end
            end else if (n_base != BK_CHAR) begin
                res_sign = SG_SIGNED;
            end
        end
        if (res_status == ST_OK && n_size != SZ_NORMAL) begin
            if (n_base == BK_CHAR || n_base == BK_FLOAT ||
                (n_size != SZ_LONG && n_base == BK_DOUBLE)) begin
                res_status = ST_BAD_SIZE;
            end
        end
        if (res_status == ST_OK) begin
            unique case (n_base)
                BK_CHAR:   res_code = {1'b0, res_sign, 8'h00};
                BK_INT:    res_code = {1'b0, res_sign, 5'b0, 3'(INT_BIAS + n_size)};
                BK_FLOAT:  res_code = CODE_FLOAT;
                BK_DOUBLE: res_code = CODE_DOUBLE | {8'b0, n_size};
                default:   res_code = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_START;
            r_sign <= SG_NONE;
            r_size <= SZ_NORMAL;
            r_base <= BK_INT;
            r_err  <= ST_OK;
        end else if (emit) begin
            r_pos  <= POS_START;
            r_sign <= SG_NONE;
            r_size <= SZ_NORMAL;
            r_base <= BK_INT;
            r_err  <= ST_OK;
        end else if (o_pop) begin
            r_pos  <= n_pos;
            r_sign <= n_sign;
            r_size <= n_size;
            r_base <= n_base;
            r_err  <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= res_status;
            r_code   <= res_code;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_status;
    assign o_out.type_code = r_code;

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK && !emit) |=> r_err == $past(r_err))
        else $error("latched error changed before name end");
    a_code_zero_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> r_code == '0)
        else $error("type code nonzero with error status");
`endif

endmodule

`default_nettype wire

// File: sv/c_type_specifier_parser.sv
`default_nettype none

// C type specifier parser. Characters of a type name arrive one per transfer on
// i_in, with token_end marking the last character of a token and name_end the
// last token of the name (name_end implies token_end). The front end folds each
// character into a 32-bit FNV-1a hash through one constant multiply and hands
// each finished token to a small queue; the back end matches the token hash
// against the keywords signed, unsigned, short, long, char, int, float and
// double, steps the position machine and latches the first error. At name end
// one result leaves on o_out: status (0 ok, 1 unexpected token, 2 bad size
// qualifier, 3 bad sign qualifier) and an 11-bit type code with the sign in
// bits 9:8, zero whenever status is nonzero. Names with no characters are not
// supported. Throughput is one character per cycle while the front is not
// stalled; the result of a name passes through the queue, then the output
// register. The front stalls only when the queue is full. The back end drains
// ordinary tokens every cycle, so this happens only when a name end reaches the
// head of the queue while the output register still holds a result that the
// sink has not taken, and the tokens that follow fill the queue behind it.
module c_type_specifier_parser
    import tsp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = TOK_QUEUE_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tsp_in_if.sink     i_in,
    tsp_out_if.source  o_out
);

    t_qpush q_ctl;
    logic   q_push;
    logic   q_full;
    t_tok   front_tok;
    t_tok   back_tok;
    logic   q_valid;
    logic   q_pop;

    // Bundle the push request and the full flag for the queue
    assign q_ctl = '{push: q_push, full: q_full};

    // Front: hash the characters, push each finished token
    tsp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_tok    (front_tok)
    );

    // Queue: decouple the character stream from keyword decode and output stalls
    tsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_tok   (front_tok),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_tok   (back_tok),
        .i_pop   (q_pop)
    );

    // Back: classify tokens, advance the position machine, emit at name end
    tsp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_tok     (back_tok),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
